/* rtl/core/ycr_pkg.sv */
// Shared constants and types for the YCbCr to RGB block pixel core.
// Used by every module of the core; depends on nothing.
`default_nettype none

package ycr_pkg;

	// Fixed field widths
	localparam int BLK_W      = 26;   // block index
	localparam int POS_W      = 6;    // pixel position inside the block
	localparam int DIM_W      = 16;   // image width and height
	localparam int PIX_W      = 8;    // one colour component
	localparam int OFF_W      = 32;   // raster offset
	localparam int XB_W       = 14;   // blocks per row, up to 8192
	localparam int ROW_W      = BLK_W + 3;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = DIM_W;

	localparam int SAMPLE_WIDTH_DEF = 11;

	// Unsigned Q16 coefficients, rounded to nearest
	localparam int COEF_CR_R   = 91881;   // 1.402
	localparam int COEF_CB_G   = 22554;   // 0.34414
	localparam int COEF_CR_G   = 46802;   // 0.71414
	localparam int COEF_CB_B   = 116130;  // 1.772
	localparam int LEVEL_SHIFT = 128;

	// Register reset values
	localparam logic [DIM_W-1:0] WIDTH_RST  = 16'd8;
	localparam logic [DIM_W-1:0] HEIGHT_RST = 16'd8;
	localparam logic             MODE_RST   = 1'b1;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_IMAGE_WIDTH  = 2'd0,
		CFG_IMAGE_HEIGHT = 2'd1,
		CFG_COLOR_MODE   = 2'd2
	} cfg_index_t;

	typedef struct packed {
		logic [PIX_W-1:0] blue;
		logic [PIX_W-1:0] green;
		logic [PIX_W-1:0] red;
	} rgb_t;

	// Carried alongside the colour stages
	typedef struct packed {
		logic [POS_W-1:0] pos;
		logic [BLK_W-1:0] blk;
	} pix_pos_t;

	// Carried alongside the divider stages
	typedef struct packed {
		rgb_t             rgb;
		logic [POS_W-1:0] pos;
	} div_tag_t;

	// Image geometry from the configuration registers
	typedef struct packed {
		logic [DIM_W-1:0] width;
		logic [DIM_W-1:0] height;
	} geom_t;

	// One result, red in the lowest bits
	typedef struct packed {
		logic             write_enable;
		logic [OFF_W-1:0] pixel_offset;
		logic [PIX_W-1:0] blue;
		logic [PIX_W-1:0] green;
		logic [PIX_W-1:0] red;
	} res_t;

	localparam int RES_W       = $bits(res_t);
	localparam int OUT_TDATA_W = ((RES_W + 7) / 8) * 8;

endpackage

`default_nettype wire

/* rtl/core/ycr_color.sv */
// Three-stage colour conversion: products, sums, floor and saturation.
// Depends on ycr_pkg.
`default_nettype none

module ycr_color
	import ycr_pkg::*;
#(
	parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF,
	parameter int TAG_W        = 1
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           en,
	input  wire logic                           color_mode,
	input  wire logic                           in_valid,
	input  wire logic signed [SAMPLE_WIDTH-1:0] luma,
	input  wire logic signed [SAMPLE_WIDTH-1:0] chroma_blue,
	input  wire logic signed [SAMPLE_WIDTH-1:0] chroma_red,
	input  wire logic        [TAG_W-1:0]        in_tag,
	output      logic                           out_valid,
	output      rgb_t                           out_rgb,
	output      logic        [TAG_W-1:0]        out_tag
);

	localparam int BASE_W = SAMPLE_WIDTH + 1;
	localparam int PROD_W = SAMPLE_WIDTH + 18;
	localparam int ACC_W  = SAMPLE_WIDTH + 19;

	localparam logic signed [PROD_W-1:0] K_CR_R = PROD_W'(COEF_CR_R);
	localparam logic signed [PROD_W-1:0] K_CB_G = PROD_W'(COEF_CB_G);
	localparam logic signed [PROD_W-1:0] K_CR_G = PROD_W'(COEF_CR_G);
	localparam logic signed [PROD_W-1:0] K_CB_B = PROD_W'(COEF_CB_B);
	localparam logic signed [BASE_W-1:0] K_SHIFT = BASE_W'(LEVEL_SHIFT);

	// Floor of a Q16 value (drop the fraction), then clamp to 0..255
	function automatic logic [PIX_W-1:0] sat8(input logic signed [ACC_W-1:0] a);
		logic [PIX_W-1:0] r;
		if (a[ACC_W-1])
			r = '0;
		else if (|a[ACC_W-2:16+PIX_W])
			r = '1;
		else
			r = a[16+PIX_W-1:16];
		return r;
	endfunction

	logic                     vld_s1, vld_s2, vld_s3;
	logic signed [BASE_W-1:0] base_s1;
	logic signed [PROD_W-1:0] crr_s1, cbg_s1, crg_s1, cbb_s1;
	logic        [TAG_W-1:0]  tag_s1, tag_s2, tag_s3;
	logic signed [ACC_W-1:0]  accr_s2, accg_s2, accb_s2;
	rgb_t                     rgb_s3;
	logic signed [ACC_W-1:0]  base_q16;

	assign base_q16 = ACC_W'(base_s1) <<< 16;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else if (en) begin
			vld_s1 <= in_valid;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			base_s1 <= BASE_W'(luma) + K_SHIFT;
			crr_s1  <= PROD_W'(chroma_red) * K_CR_R;
			cbg_s1  <= PROD_W'(chroma_blue) * K_CB_G;
			crg_s1  <= PROD_W'(chroma_red) * K_CR_G;
			cbb_s1  <= PROD_W'(chroma_blue) * K_CB_B;
			tag_s1  <= in_tag;

			if (color_mode) begin
				accr_s2 <= base_q16 + ACC_W'(crr_s1);
				accg_s2 <= base_q16 - ACC_W'(cbg_s1) - ACC_W'(crg_s1);
				accb_s2 <= base_q16 + ACC_W'(cbb_s1);
			end else begin
				// grey: all three follow Y alone
				accr_s2 <= base_q16;
				accg_s2 <= base_q16;
				accb_s2 <= base_q16;
			end
			tag_s2 <= tag_s1;

			rgb_s3.red   <= sat8(accr_s2);
			rgb_s3.green <= sat8(accg_s2);
			rgb_s3.blue  <= sat8(accb_s2);
			tag_s3       <= tag_s2;
		end
	end

	assign out_valid = vld_s3;
	assign out_rgb   = rgb_s3;
	assign out_tag   = tag_s3;

endmodule

`default_nettype wire

/* rtl/core/ycr_div.sv */
// Pipelined restoring divider, one quotient bit per register stage.
// Depends on ycr_pkg.
`default_nettype none

module ycr_div
	import ycr_pkg::*;
#(
	parameter int DVD_W = BLK_W,
	parameter int DSR_W = XB_W,
	parameter int TAG_W = 1
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             en,
	input  wire logic             in_valid,
	input  wire logic [DVD_W-1:0] in_dvd,
	input  wire logic [DSR_W-1:0] dsr,      // nonzero, held steady while busy
	input  wire logic [TAG_W-1:0] in_tag,
	output      logic             out_valid,
	output      logic [DVD_W-1:0] out_quo,
	output      logic [DSR_W-1:0] out_rem,
	output      logic [TAG_W-1:0] out_tag
);

	logic [DVD_W-1:0] vld_s;
	logic [DSR_W-1:0] rem_s  [DVD_W];
	logic [DVD_W-1:0] dvd_s  [DVD_W];   // remaining dividend bits, quotient shifts in
	logic [TAG_W-1:0] tag_s  [DVD_W];
	logic [DSR_W-1:0] rem_nx [DVD_W];
	logic [DVD_W-1:0] dvd_nx [DVD_W];

	always_comb begin
		logic [DSR_W-1:0] r;
		logic [DVD_W-1:0] d;
		logic [DSR_W:0]   trial;
		logic             ge;
		for (int i = 0; i < DVD_W; i++) begin
			if (i == 0) begin
				r = '0;
				d = in_dvd;
			end else begin
				r = rem_s[i-1];
				d = dvd_s[i-1];
			end
			trial     = {r, d[DVD_W-1]};
			ge        = trial >= {1'b0, dsr};
			rem_nx[i] = ge ? DSR_W'(trial - {1'b0, dsr}) : DSR_W'(trial);
			dvd_nx[i] = {d[DVD_W-2:0], ge};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_s <= '0;
		else if (en)
			vld_s <= {vld_s[DVD_W-2:0], in_valid};
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < DVD_W; i++) begin
				rem_s[i] <= rem_nx[i];
				dvd_s[i] <= dvd_nx[i];
				tag_s[i] <= (i == 0) ? in_tag : tag_s[(i == 0) ? 0 : i-1];
			end
		end
	end

	assign out_valid = vld_s[DVD_W-1];
	assign out_quo   = dvd_s[DVD_W-1];
	assign out_rem   = rem_s[DVD_W-1];
	assign out_tag   = tag_s[DVD_W-1];

endmodule

`default_nettype wire

/* rtl/core/ycr_addr.sv */
// Two-stage raster placement: row times width and bounds compares, then add column and combine the checks.
// Depends on ycr_pkg.
`default_nettype none

module ycr_addr
	import ycr_pkg::*;
(
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             en,
	input  wire geom_t            geom,
	input  wire logic             in_valid,
	input  wire logic [BLK_W-1:0] quo,
	input  wire logic [XB_W-1:0]  rem,
	input  wire logic [POS_W-1:0] pos,
	input  wire rgb_t             rgb,
	output      logic             out_valid,
	output      res_t             out_res
);

	localparam int MUL_W = ROW_W + DIM_W;

	logic [ROW_W-1:0] row;
	logic [DIM_W-1:0] col;
	logic [MUL_W-1:0] prod;

	logic             vld_s1, vld_s2;
	logic [OFF_W-1:0] prod_s1;
	logic [DIM_W-1:0] col_s1;
	logic             col_ok_s1, row_ok_s1;
	rgb_t             rgb_s1;
	res_t             res_s2;

	// remainder stays below 8192, so its low 13 bits carry it all
	assign row  = {quo, pos[POS_W-1:3]};
	assign col  = {rem[XB_W-2:0], pos[2:0]};
	assign prod = MUL_W'(row) * MUL_W'(geom.width);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else if (en) begin
			vld_s1 <= in_valid;
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			prod_s1   <= prod[OFF_W-1:0];
			col_s1    <= col;
			col_ok_s1 <= col < geom.width;
			row_ok_s1 <= row < ROW_W'(geom.height);
			rgb_s1    <= rgb;

			res_s2.pixel_offset <= prod_s1 + OFF_W'(col_s1);
			res_s2.write_enable <= col_ok_s1 & row_ok_s1;
			res_s2.red          <= rgb_s1.red;
			res_s2.green        <= rgb_s1.green;
			res_s2.blue         <= rgb_s1.blue;
		end
	end

	assign out_valid = vld_s2;
	assign out_res   = res_s2;

endmodule

`default_nettype wire

/* rtl/core/ycbcr_to_rgb_block_pixel_core.sv */
// Top level of the YCbCr to RGB block pixel core: registers, pipeline, output buffer.
// Depends on ycr_pkg, ycr_color, ycr_div and ycr_addr.
//
// Usage
//   Slave side (s_tvalid/s_tready/s_tdata) takes one pixel of an 8x8 block per
//   transaction: block index, position in the block and level-shifted Y, Cb, Cr.
//   Master side (m_tvalid/m_tready/m_tdata) returns one transaction per pixel in
//   the same order: clamped R, G, B, the raster offset and the in-image flag.
//   The configuration port (cfg_we, cfg_index, cfg_data) sets image width,
//   height and colour mode; write it only while no pixel is in flight.
// Pipeline and throughput
//   One pixel per cycle while the output does not stall. 32 register stages: 3 colour
//   stages, 26 divider stages (one quotient bit of block index over blocks per
//   row each), 2 placement stages, 1 output register, which drives m_tdata.
// Reset
//   arst_n clears every valid bit and loads width 8, height 8, colour mode on.
// Stalls
//   A two-entry output buffer keeps s_tready registered. When m_tready is low the
//   second entry fills, s_tready drops and the whole pipeline holds in place.
`default_nettype none

module ycbcr_to_rgb_block_pixel_core
	import ycr_pkg::*;
#(
	parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF,
	localparam int IN_W        = BLK_W + POS_W + 3 * SAMPLE_WIDTH,
	localparam int IN_TDATA_W  = ((IN_W + 7) / 8) * 8
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	// fields from bit 0 up: block_index, pixel_in_block, luma, chroma_blue, chroma_red
	input  wire logic [IN_TDATA_W-1:0] s_tdata,
	input  wire logic                  s_tvalid,
	output      logic                  s_tready,
	// fields from bit 0 up: red, green, blue, pixel_offset, write_enable
	output      logic [OUT_TDATA_W-1:0] m_tdata,
	output      logic                  m_tvalid,
	input  wire logic                  m_tready,
	input  wire logic                  cfg_we,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data
);

	localparam int SW = SAMPLE_WIDTH;

	// ---------------------------------------------------------------- config
	geom_t geom_q;
	logic  mode_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			geom_q.width  <= WIDTH_RST;
			geom_q.height <= HEIGHT_RST;
			mode_q        <= MODE_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_IMAGE_WIDTH:  geom_q.width  <= cfg_data[DIM_W-1:0];
				CFG_IMAGE_HEIGHT: geom_q.height <= cfg_data[DIM_W-1:0];
				CFG_COLOR_MODE:   mode_q        <= cfg_data[0];
				default:          ;   // unused index: drop the write
			endcase
		end
	end

	// Blocks per row, rounded up; a zero width still divides by one
	logic [DIM_W:0]   xb_sum;
	logic [XB_W-1:0]  xb_raw;
	logic [XB_W-1:0]  xb;

	assign xb_sum = {1'b0, geom_q.width} + (DIM_W+1)'(7);
	assign xb_raw = xb_sum[DIM_W:3];
	assign xb     = (xb_raw == '0) ? XB_W'(1) : xb_raw;

	// ---------------------------------------------------------------- flow
	// Every stage advances together while the output buffer has room
	logic en;
	logic skid_v_q;

	assign en       = !skid_v_q;
	assign s_tready = en;

	// ---------------------------------------------------------------- unpack
	pix_pos_t        in_pos;
	logic signed [SW-1:0] in_y, in_cb, in_cr;

	assign in_pos.blk = s_tdata[BLK_W-1:0];
	assign in_pos.pos = s_tdata[BLK_W+POS_W-1:BLK_W];
	assign in_y       = s_tdata[BLK_W+POS_W+SW-1:BLK_W+POS_W];
	assign in_cb      = s_tdata[BLK_W+POS_W+2*SW-1:BLK_W+POS_W+SW];
	assign in_cr      = s_tdata[BLK_W+POS_W+3*SW-1:BLK_W+POS_W+2*SW];

	// ---------------------------------------------------------------- colour
	logic     col_valid;
	rgb_t     col_rgb;
	pix_pos_t col_pos;

	ycr_color #(
		.SAMPLE_WIDTH (SAMPLE_WIDTH),
		.TAG_W        ($bits(pix_pos_t))
	) u_color (
		.clk         (clk),
		.arst_n      (arst_n),
		.en          (en),
		.color_mode  (mode_q),
		.in_valid    (s_tvalid),
		.luma        (in_y),
		.chroma_blue (in_cb),
		.chroma_red  (in_cr),
		.in_tag      (in_pos),
		.out_valid   (col_valid),
		.out_rgb     (col_rgb),
		.out_tag     (col_pos)
	);

	// ---------------------------------------------------------------- divide
	div_tag_t         div_in_tag, div_out_tag;
	logic             div_valid;
	logic [BLK_W-1:0] div_quo;
	logic [XB_W-1:0]  div_rem;

	assign div_in_tag.rgb = col_rgb;
	assign div_in_tag.pos = col_pos.pos;

	ycr_div #(
		.DVD_W (BLK_W),
		.DSR_W (XB_W),
		.TAG_W ($bits(div_tag_t))
	) u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (col_valid),
		.in_dvd    (col_pos.blk),
		.dsr       (xb),
		.in_tag    (div_in_tag),
		.out_valid (div_valid),
		.out_quo   (div_quo),
		.out_rem   (div_rem),
		.out_tag   (div_out_tag)
	);

	// ---------------------------------------------------------------- place
	logic addr_valid;
	res_t addr_res;

	ycr_addr u_addr (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.geom      (geom_q),
		.in_valid  (div_valid),
		.quo       (div_quo),
		.rem       (div_rem),
		.pos       (div_out_tag.pos),
		.rgb       (div_out_tag.rgb),
		.out_valid (addr_valid),
		.out_res   (addr_res)
	);

	// ---------------------------------------------------------------- output
	// Main register drives the port; the skid entry catches the one result
	// that arrives in the cycle the receiver stalls.
	logic push;
	logic out_v_q;
	res_t out_q, skid_q;

	assign push = addr_valid && en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q  <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (skid_v_q) begin
			if (m_tready)
				skid_v_q <= 1'b0;
		end else if (!out_v_q || m_tready) begin
			out_v_q <= push;
		end else if (push) begin
			skid_v_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_v_q) begin
			if (m_tready)
				out_q <= skid_q;
		end else if (!out_v_q || m_tready) begin
			if (push)
				out_q <= addr_res;
		end else if (push) begin
			skid_q <= addr_res;
		end
	end

	assign m_tvalid = out_v_q;
	assign m_tdata  = {(OUT_TDATA_W-RES_W)'(0), out_q};

endmodule

`default_nettype wire

/* rtl/core/ycr_checker.sv */
// Port-level checks for the YCbCr to RGB block pixel core, bound to the top level.
// Depends on ycr_pkg and ycbcr_to_rgb_block_pixel_core.
`default_nettype none

module ycr_checker
	import ycr_pkg::*;
(
	input wire logic                   clk,
	input wire logic                   arst_n,
	input wire logic                   s_tready,
	input wire logic                   m_tvalid,
	input wire logic                   m_tready,
	input wire logic [OUT_TDATA_W-1:0] m_tdata
);

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result changed while stalled");

	// input side closes only behind a stalled, full output
	a_ready_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> m_tvalid && $past(m_tvalid && !m_tready))
		else $error("s_tready low without an output stall");

	// one taken result frees the skid entry at once
	a_ready_reopen: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tready && !s_tready |=> s_tready)
		else $error("s_tready did not reopen after the stall cleared");

	// padding above the result fields stays zero
	a_pad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[OUT_TDATA_W-1:RES_W] == '0)
		else $error("nonzero padding in m_tdata");

endmodule

bind ycbcr_to_rgb_block_pixel_core ycr_checker u_ycr_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);

`default_nettype wire

/* verif/ycbcr_to_rgb_pixel_checker.sv */
// Scoreboard for the YCbCr to RGB block pixel core: watches the pixel, result and register ports.
// Predicts colour, raster offset and in-image flag per accepted pixel; depends on ycr_pkg.

module ycbcr_to_rgb_pixel_checker
	import ycr_pkg::*;
#(
	parameter int SAMPLE_W = SAMPLE_WIDTH_DEF,
	localparam int IN_W       = BLK_W + POS_W + 3 * SAMPLE_W,
	localparam int IN_TDATA_W = ((IN_W + 7) / 8) * 8
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic [IN_TDATA_W-1:0]  s_tdata,
	input  wire logic                   s_tvalid,
	input  wire logic                   s_tready,
	input  wire logic [OUT_TDATA_W-1:0] m_tdata,
	input  wire logic                   m_tvalid,
	input  wire logic                   m_tready,
	input  wire logic                   cfg_we,
	input  wire logic [CFG_IDX_W-1:0]   cfg_index,
	input  wire logic [CFG_DATA_W-1:0]  cfg_data,
	output int                          mismatches,
	output int                          pending,
	output int                          checked,
	output int                          in_image
);

	logic [DIM_W-1:0] width_q;
	logic [DIM_W-1:0] height_q;
	logic             colour_q;
	res_t             awaited_pixels[$];

	// Floor a Q16 value and saturate it to one 8-bit component
	function automatic logic [PIX_W-1:0] clamp_q16(input longint q16);
		longint whole;
		whole = q16 >>> 16;
		if (whole < 0)
			return '0;
		if (whole > 255)
			return 8'd255;
		return whole[PIX_W-1:0];
	endfunction

	function automatic res_t predict_pixel(input logic [BLK_W-1:0] blk,
			input logic [POS_W-1:0] pos, input logic signed [SAMPLE_W-1:0] y,
			input logic signed [SAMPLE_W-1:0] cb, input logic signed [SAMPLE_W-1:0] cr);
		longint unsigned blocks_per_row;
		longint unsigned col;
		longint unsigned row;
		longint unsigned off;
		longint          base;
		res_t            pix;
		blocks_per_row = (longint'(width_q) + 7) >> 3;
		if (blocks_per_row == 0)
			blocks_per_row = 1;
		col = (longint'(blk) % blocks_per_row) * 8 + pos[2:0];
		row = (longint'(blk) / blocks_per_row) * 8 + pos[5:3];
		off = row * longint'(width_q) + col;
		pix.pixel_offset = off[OFF_W-1:0];
		pix.write_enable = (col < width_q) && (row < height_q);
		base = (longint'(y) + LEVEL_SHIFT) * 65536;
		if (colour_q) begin
			pix.red   = clamp_q16(base + longint'(COEF_CR_R) * longint'(cr));
			pix.green = clamp_q16(base - longint'(COEF_CB_G) * longint'(cb)
				- longint'(COEF_CR_G) * longint'(cr));
			pix.blue  = clamp_q16(base + longint'(COEF_CB_B) * longint'(cb));
		end else begin
			pix.red   = clamp_q16(base);
			pix.green = pix.red;
			pix.blue  = pix.red;
		end
		return pix;
	endfunction

	task automatic compare_field(input string name, input longint unsigned want,
			input longint unsigned got);
		if (want != got) begin
			$display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
			mismatches++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		res_t got;
		res_t want;
		if (!arst_n) begin
			width_q  <= WIDTH_RST;
			height_q <= HEIGHT_RST;
			colour_q <= MODE_RST;
			awaited_pixels.delete();
			pending    = 0;
			mismatches = 0;
			checked    = 0;
			in_image   = 0;
		end else begin
			if (m_tvalid && m_tready) begin
				got = res_t'(m_tdata[RES_W-1:0]);
				checked++;
				if (got.write_enable)
					in_image++;
				if (awaited_pixels.size() == 0) begin
					$display("%0t: result with nothing awaited, expected none, got %h",
						$time, got);
					mismatches++;
				end else begin
					want = awaited_pixels.pop_front();
					compare_field("red", want.red, got.red);
					compare_field("green", want.green, got.green);
					compare_field("blue", want.blue, got.blue);
					compare_field("pixel_offset", want.pixel_offset, got.pixel_offset);
					compare_field("write_enable", want.write_enable, got.write_enable);
				end
			end
			if (s_tvalid && s_tready)
				awaited_pixels.insert(awaited_pixels.size(), predict_pixel(s_tdata[BLK_W-1:0],
					s_tdata[BLK_W +: POS_W], s_tdata[BLK_W+POS_W +: SAMPLE_W],
					s_tdata[BLK_W+POS_W+SAMPLE_W +: SAMPLE_W],
					s_tdata[BLK_W+POS_W+2*SAMPLE_W +: SAMPLE_W]));
			pending = awaited_pixels.size();
			// register writes land after this edge's transactions
			if (cfg_we) begin
				case (cfg_index)
					CFG_IMAGE_WIDTH:  width_q  <= cfg_data[DIM_W-1:0];
					CFG_IMAGE_HEIGHT: height_q <= cfg_data[DIM_W-1:0];
					CFG_COLOR_MODE:   colour_q <= cfg_data[0];
					default: ;
				endcase
			end
		end
	end

endmodule

/* verif/ycbcr_to_rgb_block_pixel_core_tb.sv */
// Testbench top for ycbcr_to_rgb_block_pixel_core: clock, reset, pixel stimulus and verdict.
// Depends on ycr_pkg, the core and ycbcr_to_rgb_pixel_checker, which checks every result.

module ycbcr_to_rgb_block_pixel_core_tb;
	import ycr_pkg::*;

	localparam int SAMPLE_W   = SAMPLE_WIDTH_DEF;
	localparam int IN_W       = BLK_W + POS_W + 3 * SAMPLE_W;
	localparam int IN_TDATA_W = ((IN_W + 7) / 8) * 8;
	// Longest stretch with no transaction on either side before the run is abandoned
	localparam int QUIET_LIMIT = 4000;
	// Settle time at the end, a little over the pipeline latency
	localparam int DRAIN_CYCLES = 40;
	localparam int RANDOM_PHASES = 8;
	localparam int PHASE_PIXELS  = 250;
	localparam logic [BLK_W-1:0] BLK_MAX = {BLK_W{1'b1}};
	// Index 3 has no register behind it
	localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

	logic                   clk       = 1'b0;
	logic                   arst_n    = 1'b0;
	// fields from bit 0 up: block_index, pixel_in_block, luma, chroma_blue, chroma_red
	logic [IN_TDATA_W-1:0]  s_tdata   = '0;
	logic                   s_tvalid  = 1'b0;
	logic                   s_tready;
	// fields from bit 0 up: red, green, blue, pixel_offset, write_enable
	logic [OUT_TDATA_W-1:0] m_tdata;
	logic                   m_tvalid;
	logic                   m_tready  = 1'b0;
	logic                   cfg_we    = 1'b0;
	logic [CFG_IDX_W-1:0]   cfg_index = '0;
	logic [CFG_DATA_W-1:0]  cfg_data  = '0;

	int mismatches;
	int pending;
	int checked;
	int in_image;
	int pixels_sent = 0;
	int settings    = 1;
	int quiet       = 0;
	bit burst       = 1'b0;
	logic [DIM_W-1:0] cur_width  = WIDTH_RST;
	logic [DIM_W-1:0] cur_height = HEIGHT_RST;

	ycbcr_to_rgb_block_pixel_core #(.SAMPLE_WIDTH(SAMPLE_W)) DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tdata   (s_tdata),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.m_tdata   (m_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	ycbcr_to_rgb_pixel_checker #(.SAMPLE_W(SAMPLE_W)) pixel_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tdata    (s_tdata),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.m_tdata    (m_tdata),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.mismatches (mismatches),
		.pending    (pending),
		.checked    (checked),
		.in_image   (in_image)
	);

	initial begin
		forever #4 clk = ~clk;
	end

	// Idle length in cycles: mostly none or short, now and then a long one
	function automatic int idle_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(30, 60);
	endfunction

	// Image dimension for a random setting, with the extremes weighted in
	function automatic logic [DIM_W-1:0] random_dim();
		int r;
		r = $urandom_range(0, 99);
		if (r < 35)
			return DIM_W'($urandom_range(1, 24));
		if (r < 65)
			return DIM_W'($urandom_range(25, 300));
		if (r < 70)
			return '0;
		if (r < 75)
			return '1;
		if (r < 80)
			return 1;
		return DIM_W'($urandom_range(1, 65535));
	endfunction

	// Receiver: hold m_tready low for random stalls, with long stretches of no stall
	initial begin
		int run_len;
		int stall;
		@(posedge arst_n);
		@(posedge clk);
		forever begin
			run_len = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300)
				: $urandom_range(1, 20);
			m_tready <= 1'b1;
			repeat (run_len) @(posedge clk);
			stall = idle_len();
			if (stall > 0) begin
				m_tready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
		end
	end

	// Watchdog: abandon the run after too long with no transaction on either side
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
			quiet <= 0;
		else
			quiet <= quiet + 1;
		if (quiet >= QUIET_LIMIT) begin
			$display("%0t: no transaction for %0d cycles", $time, QUIET_LIMIT);
			$display("== FAIL ==");
			$finish;
		end
	end

	// Present one pixel and hold it until the core takes it. Called and returns
	// at a rising edge; s_tready is sampled on the falling edge so the decision
	// never races the core's own update.
	task automatic send_pixel(input logic [BLK_W-1:0] blk, input logic [POS_W-1:0] pos,
			input int y, input int cb, input int cr);
		logic [IN_TDATA_W-1:0]  word;
		logic [SAMPLE_W-1:0]    y_bits;
		logic [SAMPLE_W-1:0]    cb_bits;
		logic [SAMPLE_W-1:0]    cr_bits;
		bit                     took;
		int                     gap;
		y_bits  = SAMPLE_W'(y);
		cb_bits = SAMPLE_W'(cb);
		cr_bits = SAMPLE_W'(cr);
		word = '0;
		word[IN_W-1:0] = {cr_bits, cb_bits, y_bits, pos, blk};
		s_tdata  <= word;
		s_tvalid <= 1'b1;
		do begin
			@(negedge clk);
			took = s_tready;
			@(posedge clk);
		end while (!took);
		pixels_sent++;
		gap = burst ? 0 : idle_len();
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// Drop valid and hold until every awaited result has come back
	task automatic drain();
		s_tvalid <= 1'b0;
		do
			@(negedge clk);
		while (pending != 0);
		@(posedge clk);
	endtask

	// Drain, then write all three registers and poke the unused index. Colour
	// mode gets junk in its upper data bits, which the core must drop.
	task automatic configure(input logic [DIM_W-1:0] w, input logic [DIM_W-1:0] h,
			input bit colour);
		drain();
		cfg_we    <= 1'b1;
		cfg_index <= CFG_IMAGE_WIDTH;
		cfg_data  <= w;
		@(posedge clk);
		cfg_index <= CFG_IMAGE_HEIGHT;
		cfg_data  <= h;
		@(posedge clk);
		cfg_index <= CFG_COLOR_MODE;
		cfg_data  <= {(CFG_DATA_W-1)'($urandom_range(0, 32767)), colour};
		@(posedge clk);
		cfg_index <= CFG_UNUSED;
		cfg_data  <= CFG_DATA_W'($urandom_range(0, 65535));
		@(posedge clk);
		cfg_we     <= 1'b0;
		cur_width  = w;
		cur_height = h;
		settings++;
	endtask

	// Random pixel: mostly blocks near the image, some anywhere; samples mostly
	// in the natural range, the rest across the full width
	task automatic send_random_pixel();
		longint unsigned across;
		longint unsigned down;
		longint unsigned top_blk;
		logic [BLK_W-1:0] blk;
		int y;
		int cb;
		int cr;
		across = (longint'(cur_width) + 7) >> 3;
		if (across == 0)
			across = 1;
		down = (longint'(cur_height) + 7) >> 3;
		top_blk = across * (down + 1);
		if (top_blk > BLK_MAX)
			top_blk = BLK_MAX;
		if ($urandom_range(0, 9) < 7)
			blk = BLK_W'($urandom_range(0, int'(top_blk)));
		else
			blk = BLK_W'($urandom);
		if ($urandom_range(0, 9) < 6) begin
			y  = $urandom_range(0, 255) - 128;
			cb = $urandom_range(0, 320) - 160;
			cr = $urandom_range(0, 320) - 160;
		end else begin
			y  = $urandom;
			cb = $urandom;
			cr = $urandom;
		end
		send_pixel(blk, POS_W'($urandom_range(0, 63)), y, cb, cr);
	endtask

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset geometry 8x8, colour on: sample extremes, floor below zero and
		// fractional results, pixels outside the image
		send_pixel(0, 0, 0, 0, 0);
		send_pixel(0, 63, 1023, 1023, 1023);
		send_pixel(0, 7, -1024, -1024, -1024);
		send_pixel(0, 56, 1023, -1024, 1023);
		send_pixel(0, 9, -1024, 1023, -1024);
		send_pixel(0, 1, -128, 0, -1);
		send_pixel(0, 2, -127, 1, 1);
		send_pixel(1, 0, 0, 0, 0);
		send_pixel(BLK_MAX, 63, 127, 0, 0);

		// Widest image: the largest offsets, last columns straddle the edge
		configure('1, '1, 1'b1);
		send_pixel(BLK_MAX, 63, 0, 0, 0);
		send_pixel(8191, 7, 100, -50, 50);
		send_pixel(8190, 63, -100, 50, -50);

		// One-pixel image in monochrome
		configure(1, 1, 1'b0);
		send_pixel(0, 0, -1024, 5, -5);
		send_pixel(0, 0, 1023, -5, 5);
		send_pixel(0, 1, 0, 0, 0);
		send_pixel(1, 0, 0, 0, 0);
		send_pixel(0, 0, -129, 0, 0);
		send_pixel(0, 0, 127, 0, 0);

		// Zero width: one block per row and nothing written
		configure(0, 100, 1'b1);
		send_pixel(0, 0, 10, 20, 30);
		send_pixel(5, 5, -10, -20, -30);

		// Zero height: nothing written
		configure(100, 0, 1'b0);
		send_pixel(0, 0, 10, 20, 30);
		send_pixel(3, 12, 200, 0, 0);

		// Random settings, some phases at full rate on the input side
		for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
			configure(random_dim(), random_dim(), 1'($urandom_range(0, 1)));
			burst = ($urandom_range(0, 3) == 0);
			for (int i = 0; i < PHASE_PIXELS; i++) begin
				send_random_pixel();
				// now and then hold off until the pipeline is empty
				if ($urandom_range(0, 199) == 0)
					drain();
			end
			burst = 1'b0;
		end

		drain();
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Sent %0d pixels over %0d register settings; %0d results checked, %0d in image.",
			pixels_sent, settings, checked, in_image);
		$display("Widths and heights from 0 to 65535, colour and grey, full sample range.");
		if (mismatches == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule

/* sim.f */
rtl/core/ycr_pkg.sv
rtl/core/ycr_color.sv
rtl/core/ycr_div.sv
rtl/core/ycr_addr.sv
rtl/core/ycbcr_to_rgb_block_pixel_core.sv
rtl/core/ycr_checker.sv
verif/ycbcr_to_rgb_pixel_checker.sv
verif/ycbcr_to_rgb_block_pixel_core_tb.sv
